FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising edge, switched off in reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition in this cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  `ASSERT_PROP(label, clk, rst_n, (trig) |=> (cons))

`endif

FILE: rtl/core/rsd_pkg.sv
// Types and constants shared by the sprite decoder modules.
`default_nettype none

package rsd_pkg;

  // stream decode phase held by the front end
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BASE,
    PH_OP,
    PH_NIB,
    PH_SOLID,
    PH_EOL
  } phase_t;

  // work kinds passed from front end to back end
  typedef enum logic [2:0] {
    OP_START,
    OP_BASE,
    OP_SKIP,
    OP_EOL,
    OP_BACK,
    OP_END,
    OP_NIB,
    OP_SOLID
  } op_kind_t;

  // one queue entry; start fields only meaningful for OP_START
  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  arg;     // palette base, nibble pair or solid colour
    logic [5:0]  len;     // pixel count or move amount
    logic [15:0] sx;
    logic [15:0] sy;
    logic [9:0]  w;
    logic [9:0]  h;
    logic        flip_h;
    logic        flip_v;
  } op_item_t;

  // clip register bank
  typedef struct packed {
    logic        enable;
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] bottom;
  } clip_cfg_t;

  // one result word, less its last flag
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  color;
    logic        pix;
    logic        send;
  } result_t;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_ENABLE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_LEFT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_TOP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CLIP_BOTTOM = 3'd4;

  // clip box after reset
  localparam logic [15:0] CLIP_LEFT_RST   = 16'd0;
  localparam logic [15:0] CLIP_RIGHT_RST  = 16'd319;
  localparam logic [15:0] CLIP_TOP_RST    = 16'd0;
  localparam logic [15:0] CLIP_BOTTOM_RST = 16'd199;

  // stream byte codes
  localparam logic [7:0] END_OPCODE = 8'h40;
  localparam logic [1:0] CLS_EOL    = 2'b00;
  localparam logic [1:0] CLS_SKIP   = 2'b01;
  localparam logic [1:0] CLS_SOLID  = 2'b10;
  localparam logic [1:0] CLS_NIB    = 2'b11;

endpackage

`default_nettype wire

FILE: rtl/core/rsd_front.sv
// Front end: accepts input words, tracks the stream phase, queues work.
`default_nettype none

module rsd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic [15:0]        in_start_x,
  input  wire logic [15:0]        in_start_y,
  input  wire logic [9:0]         in_sprite_width,
  input  wire logic [9:0]         in_sprite_height,
  input  wire logic               in_flip_horizontal,
  input  wire logic               in_flip_vertical,
  input  wire logic               q_ready,
  output logic                    q_push,
  output rsd_pkg::op_item_t       q_item
);

  rsd_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]      rem_r, rem_nxt;

  logic            in_fire;
  logic [5:0]      len;
  logic [1:0]      cls;
  logic            is_back;
  logic            op_path;
  logic [5:0]      nib_cnt;
  rsd_pkg::phase_t op_phase;

  assign in_ready = q_ready;
  assign in_fire  = in_valid && q_ready;
  assign len      = in_data_byte[5:0];
  assign cls      = in_data_byte[7:6];

  // a byte after end of row with top bits clear and nonzero count is a back-step
  assign is_back = (phase_r == rsd_pkg::PH_EOL) && (cls == rsd_pkg::CLS_EOL) && (len != 6'd0);
  assign op_path = (phase_r == rsd_pkg::PH_OP) || ((phase_r == rsd_pkg::PH_EOL) && !is_back);
  assign nib_cnt = (rem_r >= 6'd2) ? 6'd2 : 6'd1;

  // phase after an opcode byte
  always_comb begin
    unique case (cls)
      rsd_pkg::CLS_NIB:   op_phase = (len != 6'd0) ? rsd_pkg::PH_NIB : rsd_pkg::PH_OP;
      rsd_pkg::CLS_SOLID: op_phase = rsd_pkg::PH_SOLID;
      rsd_pkg::CLS_SKIP:  op_phase = (len == 6'd0) ? rsd_pkg::PH_IDLE : rsd_pkg::PH_OP;
      default:            op_phase = rsd_pkg::PH_EOL;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    if (in_fire) begin
      if (!in_command) begin
        phase_nxt = rsd_pkg::PH_BASE;
        rem_nxt   = 6'd0;
      end else if (op_path) begin
        phase_nxt = op_phase;
        if (cls[1]) begin
          rem_nxt = len;
        end
      end else begin
        unique case (phase_r)
          rsd_pkg::PH_BASE: phase_nxt = rsd_pkg::PH_OP;
          rsd_pkg::PH_NIB: begin
            rem_nxt = rem_r - nib_cnt;
            if (rem_r == nib_cnt) begin
              phase_nxt = rsd_pkg::PH_OP;
            end
          end
          rsd_pkg::PH_SOLID: begin
            rem_nxt   = 6'd0;
            phase_nxt = rsd_pkg::PH_OP;
          end
          rsd_pkg::PH_EOL: phase_nxt = rsd_pkg::PH_OP;  // back-step
          default: ;
        endcase
      end
    end
  end

  // queue entry for the back end
  always_comb begin
    q_push        = 1'b0;
    q_item.kind   = rsd_pkg::OP_START;
    q_item.arg    = in_data_byte;
    q_item.len    = len;
    q_item.sx     = in_start_x;
    q_item.sy     = in_start_y;
    q_item.w      = in_sprite_width;
    q_item.h      = in_sprite_height;
    q_item.flip_h = in_flip_horizontal;
    q_item.flip_v = in_flip_vertical;
    if (in_fire) begin
      if (!in_command) begin
        q_push = 1'b1;
      end else if (op_path) begin
        unique case (cls)
          rsd_pkg::CLS_SKIP: begin
            q_push      = 1'b1;
            q_item.kind = (in_data_byte == rsd_pkg::END_OPCODE) ? rsd_pkg::OP_END
                                                                 : rsd_pkg::OP_SKIP;
          end
          rsd_pkg::CLS_EOL: begin
            q_push      = 1'b1;
            q_item.kind = rsd_pkg::OP_EOL;
          end
          default: ;  // runs only set up the front end
        endcase
      end else begin
        unique case (phase_r)
          rsd_pkg::PH_BASE: begin
            q_push      = 1'b1;
            q_item.kind = rsd_pkg::OP_BASE;
          end
          rsd_pkg::PH_NIB: begin
            q_push      = 1'b1;
            q_item.kind = rsd_pkg::OP_NIB;
            q_item.len  = nib_cnt;
          end
          rsd_pkg::PH_SOLID: begin
            q_push      = (rem_r != 6'd0);
            q_item.kind = rsd_pkg::OP_SOLID;
            q_item.len  = rem_r;
          end
          rsd_pkg::PH_EOL: begin
            q_push      = 1'b1;
            q_item.kind = rsd_pkg::OP_BACK;
          end
          default: ;  // idle: stream words dropped
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rsd_pkg::PH_IDLE;
      rem_r   <= 6'd0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rsd_queue.sv
// Small register queue carrying work from the front end to the back end.
`default_nettype none

module rsd_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              push_ready,
  input  wire logic         pop,
  output logic              pop_valid,
  output logic [W-1:0]      pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CntFull);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rsd_back.sv
// Back end: moves the pen, draws and clips pixels, drives the result word.
`default_nettype none

module rsd_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rsd_pkg::clip_cfg_t cfg,
  input  wire logic               q_valid,
  input  wire rsd_pkg::op_item_t  q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rsd_pkg::result_t        out_data,
  output logic                    out_last
);

  localparam int unsigned MathW = COORD_BITS + 12;
  localparam int unsigned CmpW  = (COORD_BITS > 16) ? COORD_BITS : 16;

  // architectural state
  logic [COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [COORD_BITS-1:0] pen_y_r, pen_y_nxt;
  logic [7:0]            pal_r, pal_nxt;
  logic                  mir_x_r, mir_x_nxt;
  logic                  mir_y_r, mir_y_nxt;
  logic                  clip_act_r, clip_act_nxt;
  logic [5:0]            done_r, done_nxt;

  // one-word hold so the last flag can be placed on the final visible pixel
  rsd_pkg::result_t      hold_r, hold_nxt;
  logic                  hold_v_r, hold_v_nxt;
  logic                  hold_last_r, hold_last_nxt;

  // output register
  rsd_pkg::result_t      out_r;
  logic                  out_last_r;
  logic                  out_v_r, out_v_nxt;
  logic                  out_load;
  rsd_pkg::result_t      out_ld_data;
  logic                  out_ld_last;

  logic                  adv, flush, fin, vis;
  logic [11:0]           amt;
  logic                  add;
  logic [MathW-1:0]      px_m, px_sum, px_dif;
  logic [COORD_BITS-1:0] pen_x_step, pen_y_step;
  logic [10:0]           wm1, hm1;
  logic [MathW-1:0]      start_x_m, start_y_m;
  logic signed [17:0]    sx18, sy18, rx18, by18;
  logic                  sprite_fits;
  logic signed [CmpW-1:0] pxs, pys;
  logic [7:0]            value;
  rsd_pkg::result_t      pix_res;
  rsd_pkg::result_t      end_res;

  assign adv   = !out_v_r || out_ready;
  assign flush = hold_v_r && hold_last_r;
  assign fin   = (done_r == q_item.len - 6'd1);

  // horizontal move amount and direction
  always_comb begin
    unique case (q_item.kind)
      rsd_pkg::OP_SKIP: begin
        amt = {6'd0, q_item.len};
        add = !mir_x_r;
      end
      rsd_pkg::OP_EOL: begin
        amt = {6'd0, q_item.len};
        add = mir_x_r;
      end
      rsd_pkg::OP_BACK: begin
        amt = {q_item.len, 6'd0};
        add = mir_x_r;
      end
      default: begin
        amt = 12'd1;
        add = !mir_x_r;
      end
    endcase
  end

  assign px_m       = MathW'(pen_x_r);
  assign px_sum     = px_m + MathW'(amt);
  assign px_dif     = px_m - MathW'(amt);
  assign pen_x_step = add ? px_sum[COORD_BITS-1:0] : px_dif[COORD_BITS-1:0];
  assign pen_y_step = mir_y_r ? pen_y_r - 1'b1 : pen_y_r + 1'b1;

  // start position, flipped sprites begin at the far edge
  assign wm1       = {1'b0, q_item.w} - 11'd1;
  assign hm1       = {1'b0, q_item.h} - 11'd1;
  assign start_x_m = MathW'($signed(q_item.sx)) + (q_item.flip_h ? MathW'($signed(wm1)) : '0);
  assign start_y_m = MathW'($signed(q_item.sy)) + (q_item.flip_v ? MathW'($signed(hm1)) : '0);

  // whole-sprite containment test on start
  assign sx18   = 18'($signed(q_item.sx));
  assign sy18   = 18'($signed(q_item.sy));
  assign rx18   = sx18 + 18'($signed({1'b0, q_item.w}));
  assign by18   = sy18 + 18'($signed({1'b0, q_item.h}));
  assign sprite_fits = (sx18 >= 18'($signed(cfg.left))) && (rx18 <= 18'($signed(cfg.right))) &&
                       (sy18 >= 18'($signed(cfg.top)))  && (by18 <= 18'($signed(cfg.bottom)));

  // per-pixel clip
  assign pxs = CmpW'($signed(pen_x_r));
  assign pys = CmpW'($signed(pen_y_r));
  assign vis = !clip_act_r ||
               ((pxs >= CmpW'($signed(cfg.left))) && (pxs <= CmpW'($signed(cfg.right))) &&
                (pys >= CmpW'($signed(cfg.top)))  && (pys <= CmpW'($signed(cfg.bottom))));

  // pixel colour: high nibble first for nibble pairs
  always_comb begin
    if (q_item.kind == rsd_pkg::OP_NIB) begin
      value = (done_r == 6'd0) ? {4'd0, q_item.arg[7:4]} : {4'd0, q_item.arg[3:0]};
    end else begin
      value = q_item.arg;
    end
  end

  assign pix_res = '{x: 16'(pen_x_r), y: 16'(pen_y_r), color: value + pal_r,
                     pix: 1'b1, send: 1'b0};
  assign end_res = '{x: 16'd0, y: 16'd0, color: 8'd0, pix: 1'b0, send: 1'b1};

  // work step
  always_comb begin
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    pal_nxt       = pal_r;
    mir_x_nxt     = mir_x_r;
    mir_y_nxt     = mir_y_r;
    clip_act_nxt  = clip_act_r;
    done_nxt      = done_r;
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    hold_last_nxt = hold_last_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    out_ld_data   = hold_r;
    out_ld_last   = 1'b0;
    if (adv) begin
      if (flush) begin
        out_load      = 1'b1;
        out_ld_last   = 1'b1;
        hold_v_nxt    = 1'b0;
        hold_last_nxt = 1'b0;
      end else if (q_valid) begin
        unique case (q_item.kind)
          rsd_pkg::OP_START: begin
            pen_x_nxt    = start_x_m[COORD_BITS-1:0];
            pen_y_nxt    = start_y_m[COORD_BITS-1:0];
            mir_x_nxt    = q_item.flip_h;
            mir_y_nxt    = q_item.flip_v;
            clip_act_nxt = cfg.enable && !sprite_fits;
            pal_nxt      = 8'd0;
            q_pop        = 1'b1;
          end
          rsd_pkg::OP_BASE: begin
            pal_nxt = q_item.arg;
            q_pop   = 1'b1;
          end
          rsd_pkg::OP_SKIP, rsd_pkg::OP_BACK: begin
            pen_x_nxt = pen_x_step;
            q_pop     = 1'b1;
          end
          rsd_pkg::OP_EOL: begin
            pen_x_nxt = pen_x_step;
            pen_y_nxt = pen_y_step;
            q_pop     = 1'b1;
          end
          rsd_pkg::OP_END: begin
            hold_nxt      = end_res;
            hold_v_nxt    = 1'b1;
            hold_last_nxt = 1'b1;
            q_pop         = 1'b1;
          end
          rsd_pkg::OP_NIB, rsd_pkg::OP_SOLID: begin
            pen_x_nxt = pen_x_step;
            if (vis) begin
              // an earlier pixel of this word is now known not to be the last
              if (hold_v_r) begin
                out_load = 1'b1;
              end
              hold_nxt      = pix_res;
              hold_v_nxt    = 1'b1;
              hold_last_nxt = fin;
            end else if (fin && hold_v_r) begin
              out_load      = 1'b1;
              out_ld_last   = 1'b1;
              hold_v_nxt    = 1'b0;
              hold_last_nxt = 1'b0;
            end
            if (fin) begin
              q_pop    = 1'b1;
              done_nxt = 6'd0;
            end else begin
              done_nxt = done_r + 6'd1;
            end
          end
          default: ;
        endcase
      end
    end
    out_v_nxt = out_load || (out_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      pal_r       <= 8'd0;
      mir_x_r     <= 1'b0;
      mir_y_r     <= 1'b0;
      clip_act_r  <= 1'b0;
      done_r      <= 6'd0;
      hold_v_r    <= 1'b0;
      hold_last_r <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      pal_r       <= pal_nxt;
      mir_x_r     <= mir_x_nxt;
      mir_y_r     <= mir_y_nxt;
      clip_act_r  <= clip_act_nxt;
      done_r      <= done_nxt;
      hold_v_r    <= hold_v_nxt;
      hold_last_r <= hold_last_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (out_load) begin
      out_r      <= out_ld_data;
      out_last_r <= out_ld_last;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/rle_sprite_decoder_flip_clip_top.sv
// Top level of the run-length sprite decoder with flip and clip.
//
//  channel | direction | words
//  in_     | input     | start word or one stream byte
//  out_    | output    | pixel write or end-of-sprite marker
//  cfg_    | input     | clip register write, always ready
//
// Start, palette base, skip, end of row and back-step words are handled in turn;
// nibble bytes and solid runs draw one pixel per cycle unless the output stalls.
// The word's final result waits in the hold register until its last flag is known.
// The front end takes one word a cycle while the work queue has space.
// Reset is synchronous; no clearing pass.
`default_nettype none

module rle_sprite_decoder_flip_clip_top #(
  parameter int unsigned COORD_BITS  = 16,  // pen width, 10 to 32
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_command,
  input  wire logic [7:0]                   in_data_byte,
  input  wire logic signed [15:0]           in_start_x,
  input  wire logic signed [15:0]           in_start_y,
  input  wire logic [9:0]                   in_sprite_width,
  input  wire logic [9:0]                   in_sprite_height,
  input  wire logic                         in_flip_horizontal,
  input  wire logic                         in_flip_vertical,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [15:0]                out_pixel_x,
  output logic signed [15:0]                out_pixel_y,
  output logic [7:0]                        out_pixel_color,
  output logic                              out_pixel_valid,
  output logic                              out_sprite_end,
  output logic                              out_last,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [rsd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [15:0]                  cfg_data
);

  localparam int unsigned ItemW = $bits(rsd_pkg::op_item_t);

  rsd_pkg::clip_cfg_t cfg_r, cfg_nxt;
  logic               q_push, q_ready, q_pop, q_valid;
  rsd_pkg::op_item_t  q_in, q_out;
  logic [ItemW-1:0]   q_out_bits;
  rsd_pkg::result_t   res;

  // clip register bank
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rsd_pkg::CFG_CLIP_ENABLE: cfg_nxt.enable = cfg_data[0];
        rsd_pkg::CFG_CLIP_LEFT:   cfg_nxt.left   = cfg_data;
        rsd_pkg::CFG_CLIP_RIGHT:  cfg_nxt.right  = cfg_data;
        rsd_pkg::CFG_CLIP_TOP:    cfg_nxt.top    = cfg_data;
        rsd_pkg::CFG_CLIP_BOTTOM: cfg_nxt.bottom = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.left   <= rsd_pkg::CLIP_LEFT_RST;
      cfg_r.right  <= rsd_pkg::CLIP_RIGHT_RST;
      cfg_r.top    <= rsd_pkg::CLIP_TOP_RST;
      cfg_r.bottom <= rsd_pkg::CLIP_BOTTOM_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_sprite_width    (in_sprite_width),
    .in_sprite_height   (in_sprite_height),
    .in_flip_horizontal (in_flip_horizontal),
    .in_flip_vertical   (in_flip_vertical),
    .q_ready            (q_ready),
    .q_push             (q_push),
    .q_item             (q_in)
  );

  rsd_queue #(
    .W     (ItemW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out_bits)
  );

  assign q_out = rsd_pkg::op_item_t'(q_out_bits);

  rsd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res),
    .out_last  (out_last)
  );

  assign out_pixel_x     = $signed(res.x);
  assign out_pixel_y     = $signed(res.y);
  assign out_pixel_color = res.color;
  assign out_pixel_valid = res.pix;
  assign out_sprite_end  = res.send;

endmodule

`default_nettype wire

FILE: rtl/core/rsd_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module rsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_pixel_x,
  input wire logic [15:0] out_pixel_y,
  input wire logic [7:0]  out_pixel_color,
  input wire logic        out_pixel_valid,
  input wire logic        out_sprite_end,
  input wire logic        out_last
);

  // position and colour, then the whole result word
  logic [39:0] out_fields;
  logic [42:0] out_word;

  assign out_fields = {out_pixel_x, out_pixel_y, out_pixel_color};
  assign out_word   = {out_fields, out_pixel_valid, out_sprite_end, out_last};

  // a stalled word stays offered and unchanged
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_word))

  // every word is either a pixel or the end marker, never both
  `ASSERT_PROP(a_kind, clk, rst_n, out_valid |-> (out_pixel_valid != out_sprite_end))

  // the end marker is the last word of its input and carries zero fields
  `ASSERT_PROP(a_end_last, clk, rst_n, out_valid && out_sprite_end |-> out_last)
  `ASSERT_PROP(a_end_zero, clk, rst_n, out_valid && out_sprite_end |-> out_fields == '0)

endmodule

bind rle_sprite_decoder_flip_clip_top rsd_checker u_rsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_pixel_color (out_pixel_color),
  .out_pixel_valid (out_pixel_valid),
  .out_sprite_end  (out_sprite_end),
  .out_last        (out_last)
);

`default_nettype wire

FILE: dv/rle_sprite_decoder_flip_clip_top_test.sv
// Self-checking testbench for the run-length sprite decoder with flip and clip.
`timescale 1ns / 100ps

module rle_sprite_decoder_flip_clip_top_test;

  // input word kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // receiver hold-off, once, after this many words have gone in
  localparam int HOLD_AFTER  = 60;
  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE      = 200;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         data;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [9:0]         w;
    logic [9:0]         h;
    logic               fh;
    logic               fv;
  } stim_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         color;
    logic               pix;
    logic               send;
    logic               last;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = 1'b0;
  logic [7:0]          in_data_byte = '0;
  logic signed [15:0]  in_start_x = '0;
  logic signed [15:0]  in_start_y = '0;
  logic [9:0]          in_sprite_width = '0;
  logic [9:0]          in_sprite_height = '0;
  logic                in_flip_horizontal = 1'b0;
  logic                in_flip_vertical = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [15:0]  out_pixel_x;
  logic signed [15:0]  out_pixel_y;
  logic [7:0]          out_pixel_color;
  logic                out_pixel_valid;
  logic                out_sprite_end;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [rsd_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  // decoder shadow state
  rsd_pkg::phase_t    dec_phase;
  logic [15:0]        pen_x, pen_y;
  logic [7:0]         pal_base;
  logic [5:0]         run_left;
  logic               mir_x, mir_y, clip_on;
  logic               clip_en_q;
  logic signed [15:0] box_left, box_right, box_top, box_bottom;

  stim_word_t  word_backlog[$];
  stim_word_t  offer_word;
  pixel_word_t pixel_expect[$];
  pixel_word_t word_results[$];
  pixel_word_t due_word;

  int words_queued = 0;
  int words_accepted = 0;
  int err_count = 0;
  int idle_pct = 32;
  int hold_left = 0;
  logic hold_armed = 1'b1;

  rle_sprite_decoder_flip_clip_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_sprite_width    (in_sprite_width),
    .in_sprite_height   (in_sprite_height),
    .in_flip_horizontal (in_flip_horizontal),
    .in_flip_vertical   (in_flip_vertical),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_pixel_color    (out_pixel_color),
    .out_pixel_valid    (out_pixel_valid),
    .out_sprite_end     (out_sprite_end),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  task automatic reset_decoder();
    dec_phase  = rsd_pkg::PH_IDLE;
    pen_x      = '0;
    pen_y      = '0;
    pal_base   = '0;
    run_left   = '0;
    mir_x      = 1'b0;
    mir_y      = 1'b0;
    clip_on    = 1'b0;
    clip_en_q  = 1'b0;
    box_left   = rsd_pkg::CLIP_LEFT_RST;
    box_right  = rsd_pkg::CLIP_RIGHT_RST;
    box_top    = rsd_pkg::CLIP_TOP_RST;
    box_bottom = rsd_pkg::CLIP_BOTTOM_RST;
  endtask

  // one pixel at the pen, dropped outside the box when clipping; pen always moves
  task automatic plot_pixel(input logic [7:0] value);
    logic visible;
    pixel_word_t r;
    visible = !clip_on ||
              ($signed(pen_x) >= box_left && $signed(pen_x) <= box_right &&
               $signed(pen_y) >= box_top && $signed(pen_y) <= box_bottom);
    if (visible) begin
      r.x = pen_x;
      r.y = pen_y;
      r.color = value + pal_base;
      r.pix = 1'b1;
      r.send = 1'b0;
      r.last = 1'b0;
      word_results.push_back(r);
    end
    pen_x = mir_x ? pen_x - 16'd1 : pen_x + 16'd1;
  endtask

  task automatic shift_pen_x(input logic [15:0] amount, input logic forward);
    if (forward != mir_x) pen_x = pen_x + amount;
    else pen_x = pen_x - amount;
  endtask

  task automatic run_opcode(input logic [7:0] b);
    pixel_word_t r;
    case (b[7:6])
      rsd_pkg::CLS_NIB: begin
        run_left = b[5:0];
        dec_phase = (b[5:0] != 0) ? rsd_pkg::PH_NIB : rsd_pkg::PH_OP;
      end
      rsd_pkg::CLS_SOLID: begin
        run_left = b[5:0];
        dec_phase = rsd_pkg::PH_SOLID;
      end
      rsd_pkg::CLS_SKIP: begin
        if (b == rsd_pkg::END_OPCODE) begin
          r = '0;
          r.send = 1'b1;
          word_results.push_back(r);
          dec_phase = rsd_pkg::PH_IDLE;
        end else begin
          shift_pen_x(16'(b[5:0]), 1'b1);
          dec_phase = rsd_pkg::PH_OP;
        end
      end
      default: begin
        pen_y = mir_y ? pen_y - 16'd1 : pen_y + 16'd1;
        shift_pen_x(16'(b[5:0]), 1'b0);
        dec_phase = rsd_pkg::PH_EOL;
      end
    endcase
  endtask

  // work out the results of one accepted word and queue them
  task automatic decode_word(input stim_word_t wd);
    int sx_i, sy_i, w_i, h_i;
    logic sprite_fits;
    word_results.delete();
    if (wd.cmd == CMD_START) begin
      sx_i = int'(wd.sx);
      sy_i = int'(wd.sy);
      w_i = int'(wd.w);
      h_i = int'(wd.h);
      mir_x = wd.fh;
      mir_y = wd.fv;
      // box test on the unflipped sprite, right and bottom compared exclusive
      sprite_fits = sx_i >= box_left && sx_i + w_i <= box_right &&
                    sy_i >= box_top && sy_i + h_i <= box_bottom;
      clip_on = clip_en_q && !sprite_fits;
      pen_x = wd.sx + (wd.fh ? 16'(wd.w) - 16'd1 : 16'd0);
      pen_y = wd.sy + (wd.fv ? 16'(wd.h) - 16'd1 : 16'd0);
      pal_base = '0;
      run_left = '0;
      dec_phase = rsd_pkg::PH_BASE;
    end else begin
      case (dec_phase)
        rsd_pkg::PH_BASE: begin
          pal_base = wd.data;
          dec_phase = rsd_pkg::PH_OP;
        end
        rsd_pkg::PH_OP: run_opcode(wd.data);
        rsd_pkg::PH_NIB: begin
          plot_pixel({4'h0, wd.data[7:4]});
          if (run_left > 0) run_left--;
          if (run_left > 0) begin
            plot_pixel(wd.data & 8'h0f);
            run_left--;
          end
          if (run_left == 0) dec_phase = rsd_pkg::PH_OP;
        end
        rsd_pkg::PH_SOLID: begin
          while (run_left > 0) begin
            plot_pixel(wd.data);
            run_left--;
          end
          dec_phase = rsd_pkg::PH_OP;
        end
        rsd_pkg::PH_EOL: begin
          // a back-step byte pulls x further by 64 units a step
          if (wd.data[7:6] == rsd_pkg::CLS_EOL && wd.data[5:0] != 0) begin
            shift_pen_x({4'h0, wd.data[5:0], 6'h00}, 1'b0);
            dec_phase = rsd_pkg::PH_OP;
          end else begin
            run_opcode(wd.data);
          end
        end
        default: ;
      endcase
    end
    if (word_results.size() > 0) word_results[word_results.size() - 1].last = 1'b1;
    foreach (word_results[i]) pixel_expect.push_back(word_results[i]);
  endtask

  // random content everywhere, so that unused fields toggle too
  function automatic stim_word_t rand_word(input logic cmd);
    stim_word_t r;
    r.cmd  = cmd;
    r.data = 8'($urandom);
    r.sx   = 16'($urandom);
    r.sy   = 16'($urandom);
    r.w    = 10'($urandom);
    r.h    = 10'($urandom);
    r.fh   = 1'($urandom);
    r.fv   = 1'($urandom);
    return r;
  endfunction

  task automatic queue_word(input stim_word_t wd);
    word_backlog.push_back(wd);
    words_queued++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    stim_word_t r;
    r = rand_word(CMD_BYTE);
    r.data = b;
    queue_word(r);
  endtask

  task automatic queue_start(input logic signed [15:0] sx, input logic signed [15:0] sy,
                             input logic [9:0] w, input logic [9:0] h,
                             input logic fh, input logic fv);
    stim_word_t r;
    r = rand_word(CMD_START);
    r.sx = sx;
    r.sy = sy;
    r.w  = w;
    r.h  = h;
    r.fh = fh;
    r.fv = fv;
    queue_word(r);
  endtask

  // mostly well-formed sprites with random content, some noise and broken ones
  task automatic queue_random_sprite(inout int count);
    int n_ops, k, n, sel;
    logic signed [15:0] sx, sy;
    logic [9:0] w, h;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) queue_word(rand_word(1'($urandom_range(1))));
      count += n;
      return;
    end
    if ($urandom_range(3) == 0) begin
      sx = 16'($urandom);
      sy = 16'($urandom);
    end else begin
      sx = 16'($urandom_range(400) - 40);
      sy = 16'($urandom_range(280) - 40);
    end
    sel = $urandom_range(99);
    w = 10'((sel < 70) ? $urandom_range(1, 24) : (sel < 85) ? $urandom : $urandom_range(3));
    sel = $urandom_range(99);
    h = 10'((sel < 70) ? $urandom_range(1, 24) : (sel < 85) ? $urandom : $urandom_range(3));
    queue_start(sx, sy, w, h, 1'($urandom_range(1)), 1'($urandom_range(1)));
    queue_byte(8'($urandom));
    count += 2;
    n_ops = $urandom_range(2, 10);
    for (k = 0; k < n_ops; k++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        queue_byte(8'($urandom));
        count++;
      end else if (sel < 36) begin
        n = ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(10);
        queue_byte({rsd_pkg::CLS_NIB, 6'(n)});
        count++;
        repeat ((n + 1) / 2) begin
          queue_byte(8'($urandom));
          count++;
        end
      end else if (sel < 60) begin
        queue_byte({rsd_pkg::CLS_SOLID, 6'($urandom_range(63))});
        queue_byte(8'($urandom));
        count += 2;
      end else if (sel < 72) begin
        queue_byte({rsd_pkg::CLS_SKIP, 6'($urandom_range(1, 63))});
        count++;
      end else begin
        queue_byte({rsd_pkg::CLS_EOL, 6'($urandom_range(63))});
        count++;
        if ($urandom_range(1)) begin
          queue_byte({rsd_pkg::CLS_EOL, 6'($urandom_range(1, 63))});
          count++;
        end
      end
    end
    // now and then the sprite is left open and the next start abandons it
    if ($urandom_range(9) != 0) begin
      queue_byte(rsd_pkg::END_OPCODE);
      count++;
    end
  endtask

  // register write; the shadow copy follows at the handshake
  task automatic write_reg(input logic [rsd_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      rsd_pkg::CFG_CLIP_ENABLE: clip_en_q = val[0];
      rsd_pkg::CFG_CLIP_LEFT:   box_left = val;
      rsd_pkg::CFG_CLIP_RIGHT:  box_right = val;
      rsd_pkg::CFG_CLIP_TOP:    box_top = val;
      rsd_pkg::CFG_CLIP_BOTTOM: box_bottom = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_clip(input logic en, input logic [15:0] l, input logic [15:0] r,
                              input logic [15:0] t, input logic [15:0] b);
    logic [15:0] en_word;
    en_word = 16'($urandom);
    en_word[0] = en;
    write_reg(rsd_pkg::CFG_CLIP_ENABLE, en_word);
    write_reg(rsd_pkg::CFG_CLIP_LEFT, l);
    write_reg(rsd_pkg::CFG_CLIP_RIGHT, r);
    write_reg(rsd_pkg::CFG_CLIP_TOP, t);
    write_reg(rsd_pkg::CFG_CLIP_BOTTOM, b);
  endtask

  // all words in, all results out, then enough cycles for queued runs with no result
  task automatic wait_drained();
    while (words_accepted != words_queued || pixel_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_word(offer_word);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (word_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          offer_word = word_backlog.pop_front();
          in_valid           <= 1'b1;
          in_command         <= offer_word.cmd;
          in_data_byte       <= offer_word.data;
          in_start_x         <= offer_word.sx;
          in_start_y         <= offer_word.sy;
          in_sprite_width    <= offer_word.w;
          in_sprite_height   <= offer_word.h;
          in_flip_horizontal <= offer_word.fh;
          in_flip_vertical   <= offer_word.fv;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && words_accepted >= HOLD_AFTER) begin
      hold_left  <= HOLD_CYCLES;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixel_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected word x=%0d y=%0d colour=%0h",
                                  out_pixel_x, out_pixel_y, out_pixel_color));
      end else begin
        due_word = pixel_expect.pop_front();
        if (out_pixel_x !== due_word.x)
          report_mismatch($sformatf("pixel_x %0d, want %0d", out_pixel_x, due_word.x));
        if (out_pixel_y !== due_word.y)
          report_mismatch($sformatf("pixel_y %0d, want %0d", out_pixel_y, due_word.y));
        if (out_pixel_color !== due_word.color)
          report_mismatch($sformatf("pixel_color %0h, want %0h",
                                    out_pixel_color, due_word.color));
        if (out_pixel_valid !== due_word.pix)
          report_mismatch($sformatf("pixel_valid %0b, want %0b",
                                    out_pixel_valid, due_word.pix));
        if (out_sprite_end !== due_word.send)
          report_mismatch($sformatf("sprite_end %0b, want %0b",
                                    out_sprite_end, due_word.send));
        if (out_last !== due_word.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, due_word.last));
      end
    end
  end

  // run limit
  initial begin
    #3_200_000;
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus and phases
  initial begin : main
    int ph;
    int phase_items;
    logic signed [15:0] a, b, c, d;
    reset_decoder();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sequence, clipping off as after reset
    queue_byte(8'hff);                               // stray byte while idle
    queue_start(16'sd10, 16'sd20, 10'd8, 10'd4, 1'b0, 1'b0);
    queue_byte(8'hff);                               // palette base, colours wrap
    queue_byte({rsd_pkg::CLS_NIB, 6'd3});            // odd nibble run
    queue_byte(8'hff);
    queue_byte(8'h0a);                               // tail takes the high nibble only
    queue_byte({rsd_pkg::CLS_SOLID, 6'd63});         // longest solid run
    queue_byte(8'h00);
    queue_byte({rsd_pkg::CLS_SOLID, 6'd0});          // empty solid run still eats colour
    queue_byte(8'h55);
    queue_byte({rsd_pkg::CLS_NIB, 6'd0});            // empty nibble run
    queue_byte({rsd_pkg::CLS_SKIP, 6'd63});
    queue_byte({rsd_pkg::CLS_EOL, 6'd63});
    queue_byte({rsd_pkg::CLS_EOL, 6'd63});           // back-step
    queue_byte({rsd_pkg::CLS_EOL, 6'd0});
    queue_byte({rsd_pkg::CLS_SOLID, 6'd1});          // opcode straight after end of row
    queue_byte(8'haa);
    // start in mid-sprite, both flips, extreme corner and size
    queue_start(-16'sd32768, 16'sd32767, 10'd1023, 10'd1023, 1'b1, 1'b1);
    queue_byte(8'h00);
    queue_byte({rsd_pkg::CLS_NIB, 6'd4});
    queue_byte(8'h12);
    queue_byte(8'hfe);
    queue_byte({rsd_pkg::CLS_EOL, 6'd1});
    queue_byte(rsd_pkg::END_OPCODE);                 // end straight after end of row
    queue_start(16'sd300, 16'sd190, 10'd0, 10'd0, 1'b1, 1'b0);
    queue_byte(8'h80);
    queue_byte({rsd_pkg::CLS_NIB, 6'd1});
    queue_byte(8'h3c);
    queue_byte(rsd_pkg::END_OPCODE);
    wait_drained();

    for (ph = 1; ph <= 7; ph++) begin
      idle_pct = (ph == 5) ? 0 : 32;
      case (ph)
        1: program_clip(1'b1, 16'd0, 16'd319, 16'd0, 16'd199);
        2: program_clip(1'b1, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        3: begin
          a = 16'($urandom_range(320));
          b = 16'($urandom_range(200));
          program_clip(1'b1, a, a, b, b);
        end
        4: program_clip(1'b1, 16'd200, 16'd100, 16'd150, 16'd50);
        5: begin
          program_clip(1'b0, 16'd40, 16'd60, 16'd40, 16'd60);
          write_reg(rsd_pkg::CfgIdxW'(5), 16'($urandom));
          write_reg(rsd_pkg::CfgIdxW'(6), 16'($urandom));
          write_reg(rsd_pkg::CfgIdxW'(7), 16'($urandom));
        end
        6: begin
          a = 16'($urandom_range(390) - 50);
          b = 16'($urandom_range(390) - 50);
          c = 16'($urandom_range(270) - 50);
          d = 16'($urandom_range(270) - 50);
          program_clip(1'b1, (a < b) ? a : b, (a < b) ? b : a,
                       (c < d) ? c : d, (c < d) ? d : c);
        end
        default: program_clip(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
      endcase
      phase_items = 0;
      while (phase_items < 20) queue_random_sprite(phase_items);
      wait_drained();
    end

    if (pixel_expect.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pixel_expect.size()));
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
